[hdl/bbra_pkg.sv]
// Package for the billboard rotation angle pipeline: payload structs, CORDIC
// arctangent table and fixed constants. No dependencies.
`default_nettype none
package bbra_pkg;

  typedef struct packed {
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic signed [31:0] cam_z;
    logic signed [31:0] obj_x;
    logic signed [31:0] obj_y;
    logic signed [31:0] obj_z;
  } bbra_in_t;

  typedef struct packed {
    logic               yaw_valid;
    logic signed [15:0] yaw_angle;
    logic               pitch_valid;
    logic signed [15:0] pitch_angle;
  } bbra_out_t;

  localparam int unsigned CORDIC_STEPS = 30;
  localparam logic [31:0] HALF_PI_Q30  = 32'd1686629713;
  localparam logic [14:0] CUT_NUM      = 15'd19999;
  localparam logic [26:0] CUT_DEN      = 27'd99980001;
  localparam logic [20:0] DEG_MUL      = 21'd1152000;
  localparam logic [14:0] ANGLE_MAX    = 15'd23052;

  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    begin
      unique case (i)
        5'd0:  v = 32'h3243F6A8;  5'd1:  v = 32'h1DAC6705;
        5'd2:  v = 32'h0FADBAFC;  5'd3:  v = 32'h07F56EA6;
        5'd4:  v = 32'h03FEAB76;  5'd5:  v = 32'h01FFD55B;
        5'd6:  v = 32'h00FFFAAA;  5'd7:  v = 32'h007FFF55;
        5'd8:  v = 32'h003FFFEA;  5'd9:  v = 32'h001FFFFD;
        5'd10: v = 32'h000FFFFF;  5'd11: v = 32'h0007FFFF;
        5'd12: v = 32'h0003FFFF;  5'd13: v = 32'h0001FFFF;
        5'd14: v = 32'h0000FFFF;  5'd15: v = 32'h00007FFF;
        5'd16: v = 32'h00003FFF;  5'd17: v = 32'h00001FFF;
        5'd18: v = 32'h00000FFF;  5'd19: v = 32'h000007FF;
        5'd20: v = 32'h000003FF;  5'd21: v = 32'h000001FF;
        5'd22: v = 32'h000000FF;  5'd23: v = 32'h0000007F;
        5'd24: v = 32'h0000003F;  5'd25: v = 32'h0000001F;
        5'd26: v = 32'h0000000F;  5'd27: v = 32'h00000008;
        5'd28: v = 32'h00000004;  5'd29: v = 32'h00000002;
        default: v = 32'h0;
      endcase
      return v;
    end
  endfunction

endpackage
`default_nettype wire

[hdl/billboard_rotation_angles.sv]
// Billboard rotation angles: yaw and pitch that face a sprite toward a camera.
// Pipeline from an accepted start to out_valid: front end, square
// root, CORDIC, degree scaling. Throughput one transaction per cycle;
// busy is held low, and results cannot be stalled by the receiver.
// Reset (rst_n, synchronous, low) clears only the valid pipeline.
// Depends on bbra_pkg, bbra_front, bbra_sqrt, bbra_cordic.
`default_nettype none
module billboard_rotation_angles (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  bbra_pkg::bbra_in_t   in_data,
  output logic                 out_valid,
  output bbra_pkg::bbra_out_t  out_data
);
  import bbra_pkg::*;

  logic               f_vld, f_yok, f_pok, f_yneg, f_pneg;
  logic signed [32:0] f_yx, f_yy;
  logic [31:0]        f_a, f_b, f_c;

  // fully pipelined, so the block never pushes back
  assign busy = 1'b0;

  bbra_front u_front (
    .clk, .rst_n, .vld_in(start && !busy), .din(in_data),
    .vld_out(f_vld), .yaw_ok(f_yok), .pitch_ok(f_pok),
    .yaw_neg(f_yneg), .pitch_neg(f_pneg),
    .yaw_x(f_yx), .yaw_y(f_yy), .pit_a(f_a), .pit_b(f_b), .pit_c(f_c)
  );

  // yaw operands ride alongside the square root to line up with pitch
  localparam int SIDE_W = 33 + 33 + 32 + 4;
  logic [SIDE_W-1:0] s_side;
  logic              s_vld;
  logic [31:0]       s_root;
  bbra_sqrt #(.SIDE_W(SIDE_W)) u_sqrt (
    .clk, .rst_n, .vld_in(f_vld), .a(f_a), .b(f_b),
    .side_in({f_yx, f_yy, f_c, f_yok, f_pok, f_yneg, f_pneg}),
    .vld_out(s_vld), .root(s_root), .side_out(s_side)
  );

  logic signed [32:0] s_yx, s_yy;
  logic [31:0]        s_c;
  logic               s_yok, s_pok, s_yneg, s_pneg;
  assign {s_yx, s_yy, s_c, s_yok, s_pok, s_yneg, s_pneg} = s_side;

  logic               y_vld, y_ok, p_vld, p_ok;
  logic signed [15:0] y_ang, p_ang;

  bbra_cordic u_yaw (
    .clk, .rst_n, .vld_in(s_vld), .x_in(s_yx), .y_in(s_yy),
    .ok_in(s_yok), .neg_in(s_yneg),
    .vld_out(y_vld), .ok_out(y_ok), .angle(y_ang)
  );

  bbra_cordic u_pitch (
    .clk, .rst_n, .vld_in(s_vld), .x_in($signed({1'b0, s_root})),
    .y_in($signed({1'b0, s_c})), .ok_in(s_pok), .neg_in(s_pneg),
    .vld_out(p_vld), .ok_out(p_ok), .angle(p_ang)
  );

  assign out_valid            = y_vld;
  assign out_data.yaw_valid   = y_ok;
  assign out_data.yaw_angle   = y_ang;
  assign out_data.pitch_valid = p_ok;
  assign out_data.pitch_angle = p_ang;

  // both CORDIC lanes must stay in lockstep
  a_lockstep: assert property (@(posedge clk) disable iff (!rst_n) y_vld == p_vld)
    else $error("yaw and pitch lanes out of step");
  // an invalid rotation reports a zero angle
  a_yaw_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.yaw_valid |-> out_data.yaw_angle == 16'sd0)
    else $error("invalid yaw with nonzero angle");
  a_pitch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.pitch_valid |-> out_data.pitch_angle == 16'sd0)
    else $error("invalid pitch with nonzero angle");
endmodule
`default_nettype wire

[hdl/bbra_front.sv]
// Front end: differences, magnitudes, cosine-threshold tests and operand
// normalization, four register stages. Depends on bbra_pkg.
`default_nettype none
module bbra_front (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   vld_in,
  input  bbra_pkg::bbra_in_t    din,
  output logic                  vld_out,
  output logic                  yaw_ok,
  output logic                  pitch_ok,
  output logic                  yaw_neg,
  output logic                  pitch_neg,
  output logic signed [32:0]    yaw_x,
  output logic signed [32:0]    yaw_y,
  output logic [31:0]           pit_a,
  output logic [31:0]           pit_b,
  output logic [31:0]           pit_c
);
  import bbra_pkg::*;

  // stage 1: differences
  logic              v1_r;
  logic signed [32:0] dx_r, dy_r, dz_r;
  // stage 2: magnitudes and squares
  logic              v2_r;
  logic [32:0]       ax2_r, ay2_r, az2_r;
  logic [65:0]       sx_r, sy_r, sz_r;
  logic              sxn2_r, szn2_r, syp2_r;
  // stage 3: scaled squares, normalization shift
  logic              v3_r;
  logic [80:0]       lz_r, lx_r, lxz_r;
  logic [92:0]       rx_r, ry_r;
  logic              nz3_r, sxn3_r, szn3_r, syp3_r;
  logic signed [6:0] shy3_r, shp3_r;
  logic [32:0]       ax3_r, ay3_r, az3_r;
  // stage 4: outputs
  logic              v4_r, yok4_r, pok4_r, yneg4_r, pneg4_r;
  logic signed [32:0] yx4_r, yy4_r;
  logic [31:0]       pa4_r, pb4_r, pc4_r;

  function automatic logic signed [6:0] norm_sh(input logic [32:0] m);
    logic signed [6:0] s;
    begin
      s = 7'sd0;
      if (m != 33'd0) begin
        for (int k = 0; k < 33; k++) begin
          if (m[k]) s = 7'(29 - k);
        end
      end
      return s;
    end
  endfunction

  function automatic logic [32:0] app_sh(input logic [32:0] v, input logic signed [6:0] s);
    begin
      if (s >= 0) return v << s[5:0];
      else return v >> 6'(-s);
    end
  endfunction

  function automatic logic [32:0] mag(input logic signed [32:0] v);
    begin
      return v[32] ? 33'(-v) : 33'(v);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
    end else begin
      v1_r <= vld_in; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    logic [32:0] mx, mxz, mxyz;
    dx_r <= 33'(din.cam_x) - 33'(din.obj_x);
    dy_r <= 33'(din.cam_y) - 33'(din.obj_y);
    dz_r <= 33'(din.cam_z) - 33'(din.obj_z);

    ax2_r  <= mag(dx_r); ay2_r <= mag(dy_r); az2_r <= mag(dz_r);
    sx_r   <= 66'(mag(dx_r)) * 66'(mag(dx_r));
    sy_r   <= 66'(mag(dy_r)) * 66'(mag(dy_r));
    sz_r   <= 66'(mag(dz_r)) * 66'(mag(dz_r));
    sxn2_r <= dx_r[32];
    szn2_r <= dz_r[32];
    syp2_r <= !dy_r[32] && (dy_r != 33'sd0);

    lz_r   <= 81'(sz_r) * 81'(CUT_NUM);
    lx_r   <= 81'(sx_r) * 81'(CUT_NUM);
    lxz_r  <= 81'(67'(sx_r) + 67'(sz_r)) * 81'(CUT_NUM);
    rx_r   <= 93'(sx_r) * 93'(CUT_DEN);
    ry_r   <= 93'(sy_r) * 93'(CUT_DEN);
    nz3_r  <= (ax2_r | az2_r) != 33'd0;
    sxn3_r <= sxn2_r; szn3_r <= szn2_r; syp3_r <= syp2_r;
    mx     = (ax2_r > az2_r) ? ax2_r : az2_r;
    mxyz   = (ay2_r > mx) ? ay2_r : mx;
    mxz    = mx;
    shy3_r <= norm_sh(mxz);
    shp3_r <= norm_sh(mxyz);
    ax3_r  <= ax2_r; ay3_r <= ay2_r; az3_r <= az2_r;

    yok4_r  <= 93'(lz_r) < rx_r;
    pok4_r  <= nz3_r && (93'(lxz_r) < ry_r);
    yneg4_r <= sxn3_r;
    pneg4_r <= syp3_r;
    yx4_r   <= szn3_r ? -$signed(app_sh(az3_r, shy3_r)) : $signed(app_sh(az3_r, shy3_r));
    yy4_r   <= $signed(app_sh(ax3_r, shy3_r));
    pa4_r   <= 32'(app_sh(ax3_r, shp3_r));
    pb4_r   <= 32'(app_sh(az3_r, shp3_r));
    pc4_r   <= 32'(app_sh(ay3_r, shp3_r));
  end

  assign vld_out   = v4_r;
  assign yaw_ok    = yok4_r;
  assign pitch_ok  = pok4_r;
  assign yaw_neg   = yneg4_r;
  assign pitch_neg = pneg4_r;
  assign yaw_x     = yx4_r;
  assign yaw_y     = yy4_r;
  assign pit_a     = pa4_r;
  assign pit_b     = pb4_r;
  assign pit_c     = pc4_r;
endmodule
`default_nettype wire

[hdl/bbra_sqrt.sv]
// Pipelined integer square root of a 61-bit sum, one result bit per stage
// (31 stages). Carries a side payload alongside. Depends on nothing.
`default_nettype none
module bbra_sqrt #(
  parameter int SIDE_W = 8
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               vld_in,
  input  wire  [31:0]       a,
  input  wire  [31:0]       b,
  input  wire  [SIDE_W-1:0] side_in,
  output logic              vld_out,
  output logic [31:0]       root,
  output logic [SIDE_W-1:0] side_out
);
  localparam int NS = 31;
  logic              v_r   [NS+1];
  logic [61:0]       rem_r [NS+1];
  logic [30:0]       res_r [NS+1];
  logic [SIDE_W-1:0] sd_r  [NS+1];

  // stage 0: sum of squares
  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else v_r[0] <= vld_in;
    rem_r[0] <= 62'(64'(a) * 64'(a) + 64'(b) * 64'(b));
    res_r[0] <= '0;
    sd_r[0]  <= side_in;
  end

  for (genvar s = 0; s < NS; s++) begin : g_st
    localparam int BI = NS - 1 - s;
    logic [61:0] trial;
    assign trial = (62'(res_r[s]) << (BI + 1)) | (62'd1 << (2 * BI));
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[s+1] <= 1'b0;
      else v_r[s+1] <= v_r[s];
      if (rem_r[s] >= trial) begin
        rem_r[s+1] <= rem_r[s] - trial;
        res_r[s+1] <= res_r[s] | (31'd1 << BI);
      end else begin
        rem_r[s+1] <= rem_r[s];
        res_r[s+1] <= res_r[s];
      end
      sd_r[s+1] <= sd_r[s];
    end
  end

  assign vld_out  = v_r[NS];
  assign root     = 32'(res_r[NS]);
  assign side_out = sd_r[NS];
endmodule
`default_nettype wire

[hdl/bbra_cordic.sv]
// Pipelined CORDIC vectoring atan2 (one step per stage) followed by the
// conversion to Q.7 degrees with sign and validity gating. Depends on bbra_pkg.
`default_nettype none
module bbra_cordic (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                vld_in,
  input  wire signed [32:0]  x_in,
  input  wire signed [32:0]  y_in,
  input  wire                ok_in,
  input  wire                neg_in,
  output logic               vld_out,
  output logic               ok_out,
  output logic signed [15:0] angle
);
  import bbra_pkg::*;
  localparam int NS = CORDIC_STEPS;

  logic               v_r  [NS+1];
  logic signed [34:0] x_r  [NS+1];
  logic signed [34:0] y_r  [NS+1];
  logic signed [33:0] z_r  [NS+1];
  logic               ok_r [NS+1];
  logic               ng_r [NS+1];

  // stage 0: quadrant fold for negative x
  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else v_r[0] <= vld_in;
    if (x_in < 0) begin
      x_r[0] <= 35'(y_in);
      y_r[0] <= -35'(x_in);
      z_r[0] <= 34'(HALF_PI_Q30);
    end else begin
      x_r[0] <= 35'(x_in);
      y_r[0] <= 35'(y_in);
      z_r[0] <= '0;
    end
    ok_r[0] <= ok_in;
    ng_r[0] <= neg_in;
  end

  for (genvar s = 0; s < NS; s++) begin : g_st
    logic signed [34:0] xs, ys;
    logic signed [33:0] at;
    assign xs = x_r[s] >>> s;
    assign ys = y_r[s] >>> s;
    assign at = $signed(34'(atan_q30(5'(s))));
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[s+1] <= 1'b0;
      else v_r[s+1] <= v_r[s];
      if (!y_r[s][34]) begin
        x_r[s+1] <= x_r[s] + ys;
        y_r[s+1] <= y_r[s] - xs;
        z_r[s+1] <= z_r[s] + at;
      end else begin
        x_r[s+1] <= x_r[s] - ys;
        y_r[s+1] <= y_r[s] + xs;
        z_r[s+1] <= z_r[s] - at;
      end
      ok_r[s+1] <= ok_r[s];
      ng_r[s+1] <= ng_r[s];
    end
  end

  // degree conversion: m = round(z*1152000 / (157*2^30)); reciprocal of 157
  // with one correction step
  logic        vc_r, vd_r, ve_r;
  logic [52:0] p_r;
  logic [22:0] q_r;
  logic [52:0] rem_r;
  logic        okc_r, okd_r, oke_r, ngc_r, ngd_r, nge_r;
  logic signed [15:0] ang_r;
  logic [14:0] m_e;
  logic [23:0] qd;

  localparam logic [31:0] RECIP = 32'd27356947; // slightly above 2^32/157

  always_ff @(posedge clk) begin
    logic [31:0] zc;
    logic [52:0] num;
    logic [22:0] q0;
    logic [30:0] nhi;
    logic [62:0] pr;
    if (!rst_n) begin
      vc_r <= 1'b0; vd_r <= 1'b0; ve_r <= 1'b0;
    end else begin
      vc_r <= v_r[NS]; vd_r <= vc_r; ve_r <= vd_r;
    end
    zc = z_r[NS][33] ? 32'd0 : 32'(z_r[NS]);
    p_r   <= 53'(zc) * 53'(DEG_MUL) + (53'd157 << 29);
    okc_r <= ok_r[NS]; ngc_r <= ng_r[NS];

    num   = p_r;
    nhi   = num[52:22];
    pr    = 63'(nhi) * 63'(RECIP);
    q0    = 23'(pr[62:40]);
    q_r   <= q0;
    rem_r <= num;
    okd_r <= okc_r; ngd_r <= ngc_r;

    oke_r <= okd_r; nge_r <= ngd_r;
    ang_r <= '0;
    if (okd_r) begin
      ang_r <= ngd_r ? -$signed({1'b0, m_e}) : $signed({1'b0, m_e});
    end
  end

  // quotient of (rem / 2^30) by 157: estimate from the top bits, then fix up
  always_comb begin
    logic [22:0] nq;
    logic [53:0] lo, hi;
    nq = 23'(rem_r >> 30);
    qd = 24'(q_r);
    lo = 54'(qd) * 54'd157;
    if (lo > 54'(nq)) qd = qd - 24'd1;
    hi = 54'(qd + 24'd1) * 54'd157;
    if (hi <= 54'(nq)) qd = qd + 24'd1;
    m_e = (qd > 24'(ANGLE_MAX)) ? ANGLE_MAX : 15'(qd);
  end

  assign vld_out = ve_r;
  assign ok_out  = oke_r;
  assign angle   = ang_r;
endmodule
`default_nettype wire
